### sv/bptc_pkg.sv
// Shared constants, the reciprocal table and small helpers for the
// barometric pressure and temperature compensation pipeline.
// No dependencies; every other file refers to it by scoped names.
package bptc_pkg;

    // Default number of fractional bits of the fixed-point datapath.
    localparam int FRAC_BITS_DEF = 30;

    localparam int RAW_W      = 24;   // raw reading width
    localparam int RATE_W     = 3;    // oversampling index width
    localparam int RECIP_BITS = 48;   // reciprocals are scaled by 2^48
    localparam int RECIP_W    = 31;   // largest reciprocal is below 2^31
    localparam int Q_W        = 64;   // saturating internal word
    localparam int OUT_W      = 32;   // result field width

    localparam int C12_W = 12;
    localparam int C16_W = 16;
    localparam int C20_W = 20;

    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_RATE = 3'd4;

    // Register stages from an accepted item to the last pipeline stage.
    localparam int PIPE_DEPTH = 19;

    // Scale factors selected by the oversampling index.
    localparam longint unsigned SCALE_0 = 64'd524288;
    localparam longint unsigned SCALE_1 = 64'd1572864;
    localparam longint unsigned SCALE_2 = 64'd3670016;
    localparam longint unsigned SCALE_3 = 64'd7864320;
    localparam longint unsigned SCALE_4 = 64'd253952;
    localparam longint unsigned SCALE_5 = 64'd516096;
    localparam longint unsigned SCALE_6 = 64'd1040384;
    localparam longint unsigned SCALE_7 = 64'd2088960;

    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_BITS;

    // Reciprocals rounded to nearest, halves up.
    localparam logic [RECIP_W-1:0] RECIP_0 = RECIP_W'((RECIP_ONE + SCALE_0 / 2) / SCALE_0);
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((RECIP_ONE + SCALE_1 / 2) / SCALE_1);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((RECIP_ONE + SCALE_2 / 2) / SCALE_2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((RECIP_ONE + SCALE_3 / 2) / SCALE_3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((RECIP_ONE + SCALE_4 / 2) / SCALE_4);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((RECIP_ONE + SCALE_5 / 2) / SCALE_5);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((RECIP_ONE + SCALE_6 / 2) / SCALE_6);
    localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'((RECIP_ONE + SCALE_7 / 2) / SCALE_7);

    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [RATE_W-1:0] idx);
        case (idx)
            3'd0:    return RECIP_0;
            3'd1:    return RECIP_1;
            3'd2:    return RECIP_2;
            3'd3:    return RECIP_3;
            3'd4:    return RECIP_4;
            3'd5:    return RECIP_5;
            3'd6:    return RECIP_6;
            3'd7:    return RECIP_7;
            default: return RECIP_0;
        endcase
    endfunction

    // Magnitude of a signed word; the most negative value maps to 2^63.
    function automatic logic [Q_W-1:0] mag64(input logic signed [Q_W-1:0] v);
        return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
    endfunction

endpackage

### sv/baro_pressure_temp_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// Uses bptc_pkg, bptc_scale, bptc_muli, bptc_mulq and bptc_delay.
//
// One item is a pair of raw 24-bit pressure and temperature readings; each
// accepted item yields exactly one result item holding temperature in
// hundredths of a degree and pressure in pascal. The datapath is a fixed
// 19-stage pipeline. The pressure path sets that depth: the scaler (three
// stages), the coefficient product (two), the two dependent Q-format
// multiplies of the polynomial (four stages each) with the sum between them
// (one), the three saturating sums (three), and the final shift and clamp
// (two). One item per cycle is taken in steady state, while the skid register
// is empty. A one-item skid register behind the output register lets the
// pipeline keep moving while a result waits; s_tready drops only while that
// skid register is occupied. Configuration writes take effect at once and
// are meant to happen while no item is in flight.
module baro_pressure_temp_compensation #(
    parameter int FRAC_BITS = bptc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] press_raw, [47:24] temp_raw
    input  logic [bptc_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] temp_centi, [63:32] press_pascal
    output logic [bptc_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bptc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int QW    = bptc_pkg::Q_W;
    localparam int PW    = FRAC_BITS + 7;
    localparam int RAW_W = bptc_pkg::RAW_W;
    localparam int OW    = bptc_pkg::OUT_W;
    localparam int PD    = bptc_pkg::PIPE_DEPTH;
    localparam int MW    = bptc_pkg::M_DATA_W;
    localparam int C12_W = bptc_pkg::C12_W;
    localparam int C16_W = bptc_pkg::C16_W;
    localparam int C20_W = bptc_pkg::C20_W;

    function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] x,
                                                     input logic signed [QW-1:0] y);
        logic signed [QW:0] s;
        s = {x[QW-1], x} + {y[QW-1], y};
        if (s[QW] != s[QW-1]) begin
            return s[QW] ? $signed({1'b1, {(QW-1){1'b0}}}) : $signed({1'b0, {(QW-1){1'b1}}});
        end
        return s[QW-1:0];
    endfunction

    // Signed 32-bit result from a magnitude that is already shifted down.
    function automatic logic [OW-1:0] int32_clamp(input logic [QW-1:0] m, input logic neg);
        if (neg) begin
            if (m > QW'(64'h8000_0000)) begin
                return {1'b1, {(OW-1){1'b0}}};
            end
            return OW'(-m);
        end
        if (m > QW'(64'h7FFF_FFFF)) begin
            return {1'b0, {(OW-1){1'b1}}};
        end
        return m[OW-1:0];
    endfunction

    // ---------------------------------------------------------------- config
    logic [63:0] coef_a_reg;
    logic [63:0] coef_b_reg;
    logic [15:0] coef_c_reg;
    logic [bptc_pkg::RATE_W-1:0] temp_rate_reg, press_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg     <= '0;
            coef_b_reg     <= '0;
            coef_c_reg     <= '0;
            temp_rate_reg  <= '0;
            press_rate_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                bptc_pkg::REG_COEF_A:     coef_a_reg     <= cfg_wdata;
                bptc_pkg::REG_COEF_B:     coef_b_reg     <= cfg_wdata;
                bptc_pkg::REG_COEF_C:     coef_c_reg     <= cfg_wdata[15:0];
                bptc_pkg::REG_TEMP_RATE:  temp_rate_reg  <= cfg_wdata[2:0];
                bptc_pkg::REG_PRESS_RATE: press_rate_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    logic signed [C12_W-1:0] c0, c1;
    logic signed [C20_W-1:0] c00, c10;
    logic signed [C16_W-1:0] c01, c11, c20, c21, c30;

    assign c0  = coef_a_reg[63:52];
    assign c1  = coef_a_reg[51:40];
    assign c00 = coef_a_reg[39:20];
    assign c10 = coef_a_reg[19:0];
    assign c01 = coef_b_reg[63:48];
    assign c11 = coef_b_reg[47:32];
    assign c20 = coef_b_reg[31:16];
    assign c21 = coef_b_reg[15:0];
    assign c30 = coef_c_reg;

    // Integer coefficients brought into Q format are exact left shifts.
    logic signed [QW-1:0] c20_one, c11_one, c10_one, c00_one, c0_half;

    assign c20_one = QW'(c20) <<< FRAC_BITS;
    assign c11_one = QW'(c11) <<< FRAC_BITS;
    assign c10_one = QW'(c10) <<< FRAC_BITS;
    assign c00_one = QW'(c00) <<< FRAC_BITS;
    assign c0_half = QW'(c0) <<< (FRAC_BITS - 1);

    // ---------------------------------------------------------- flow control
    logic          adv;
    logic [PD-1:0] valid_reg;
    logic          last_valid;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic          load_out, load_skid, skid_to_out;
    logic [MW-1:0] m_tdata_reg, skid_data_reg, result;

    assign adv        = !skid_valid_reg;
    assign s_tready   = adv;
    assign last_valid = valid_reg[PD-1];

    // ------------------------------------------------------------- datapath
    logic signed [RAW_W-1:0] press_raw, temp_raw;
    logic signed [PW-1:0]    p_l3, t_l3, p_l5, p_l10;
    logic signed [QW-1:0]    h1_l5, g1_l5, tq_l5, e_l5;
    logic signed [QW-1:0]    tp_l7, g1_l7, m1_l9, h3_l14, g_l11, g_l16, e_l15;
    logic signed [QW-1:0]    h2_reg, s1_reg, s2_reg, s3_reg;
    logic [QW-1:0]           pmag_reg;
    logic                    pneg_reg;
    logic [OW-1:0]           press_reg;
    logic [QW-1:0]           tmag_reg, t100_reg;
    logic                    tneg6_reg, tneg7_reg;
    logic [OW-1:0]           temp_reg, temp_l19;

    assign press_raw = s_tdata[23:0];
    assign temp_raw  = s_tdata[47:24];

    bptc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_p (
        .aclk(aclk), .en(adv), .raw_in(press_raw), .rate_idx(press_rate_reg), .scaled(p_l3)
    );

    bptc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_t (
        .aclk(aclk), .en(adv), .raw_in(temp_raw), .rate_idx(temp_rate_reg), .scaled(t_l3)
    );

    bptc_muli #(.CW(C16_W), .QW(PW)) u_muli_h1 (
        .aclk(aclk), .en(adv), .coef(c30), .q(p_l3), .addend(c20_one), .y(h1_l5)
    );

    bptc_muli #(.CW(C16_W), .QW(PW)) u_muli_g1 (
        .aclk(aclk), .en(adv), .coef(c21), .q(p_l3), .addend(c11_one), .y(g1_l5)
    );

    bptc_muli #(.CW(C12_W), .QW(PW)) u_muli_tq (
        .aclk(aclk), .en(adv), .coef(c1), .q(t_l3), .addend(c0_half), .y(tq_l5)
    );

    bptc_muli #(.CW(C16_W), .QW(PW)) u_muli_e (
        .aclk(aclk), .en(adv), .coef(c01), .q(t_l3), .addend('0), .y(e_l5)
    );

    bptc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq_tp (
        .aclk(aclk), .en(adv), .a(QW'(t_l3)), .b(QW'(p_l3)), .y(tp_l7)
    );

    bptc_delay #(.WIDTH(PW), .DEPTH(2)) u_dly_p5 (
        .aclk(aclk), .en(adv), .din(p_l3), .dout(p_l5)
    );

    bptc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq_m1 (
        .aclk(aclk), .en(adv), .a(QW'(p_l5)), .b(h1_l5), .y(m1_l9)
    );

    bptc_delay #(.WIDTH(PW), .DEPTH(5)) u_dly_p10 (
        .aclk(aclk), .en(adv), .din(p_l5), .dout(p_l10)
    );

    bptc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq_h3 (
        .aclk(aclk), .en(adv), .a(QW'(p_l10)), .b(h2_reg), .y(h3_l14)
    );

    bptc_delay #(.WIDTH(QW), .DEPTH(2)) u_dly_g1 (
        .aclk(aclk), .en(adv), .din(g1_l5), .dout(g1_l7)
    );

    bptc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq_g (
        .aclk(aclk), .en(adv), .a(tp_l7), .b(g1_l7), .y(g_l11)
    );

    bptc_delay #(.WIDTH(QW), .DEPTH(5)) u_dly_g (
        .aclk(aclk), .en(adv), .din(g_l11), .dout(g_l16)
    );

    bptc_delay #(.WIDTH(QW), .DEPTH(10)) u_dly_e (
        .aclk(aclk), .en(adv), .din(e_l5), .dout(e_l15)
    );

    bptc_delay #(.WIDTH(OW), .DEPTH(11)) u_dly_temp (
        .aclk(aclk), .en(adv), .din(temp_reg), .dout(temp_l19)
    );

    // Saturating sums follow the polynomial's evaluation order, since the
    // order decides where clipping happens.
    always_ff @(posedge aclk) begin
        if (adv) begin
            h2_reg    <= sat_add(c10_one, m1_l9);
            s1_reg    <= sat_add(c00_one, h3_l14);
            s2_reg    <= sat_add(s1_reg, e_l15);
            s3_reg    <= sat_add(s2_reg, g_l16);
            pmag_reg  <= bptc_pkg::mag64(s3_reg);
            pneg_reg  <= s3_reg[QW-1];
            press_reg <= int32_clamp(pmag_reg >> FRAC_BITS, pneg_reg);

            // Temperature: magnitude times 100 stays below 2^63.
            tmag_reg  <= bptc_pkg::mag64(tq_l5);
            tneg6_reg <= tq_l5[QW-1];
            t100_reg  <= (tmag_reg << 6) + (tmag_reg << 5) + (tmag_reg << 2);
            tneg7_reg <= tneg6_reg;
            temp_reg  <= int32_clamp(t100_reg >> FRAC_BITS, tneg7_reg);
        end
    end

    assign result = {press_reg, temp_l19};

    // ------------------------------------------------------ output and skid
    always_comb begin
        m_tvalid_next   = m_tvalid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        skid_to_out     = 1'b0;
        if (skid_valid_reg) begin
            if (m_tready) begin
                skid_to_out     = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (last_valid) begin
            if (!m_tvalid_reg || m_tready) begin
                load_out      = 1'b1;
                m_tvalid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                valid_reg <= {valid_reg[PD-2:0], s_tvalid};
            end
            m_tvalid_reg   <= m_tvalid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= result;
        end else if (skid_to_out) begin
            m_tdata_reg <= skid_data_reg;
        end
        if (load_skid) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid register holds an item while the output register is empty");

    a_stalled_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_valid && !skid_valid_reg && m_tvalid_reg && !m_tready) |=> skid_valid_reg)
        else $error("finished item was not caught by the skid register");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (!skid_valid_reg && m_tvalid_reg))
        else $error("skid item did not move into the output register");

    a_pipe_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> $stable(valid_reg))
        else $error("pipeline moved while the skid register was full");
`endif

endmodule

### sv/bptc_delay.sv
// Enable-gated register delay line used to keep operands aligned with
// the pipeline stage that consumes them. Uses bptc_pkg for its default width.
module bptc_delay #(
    parameter int WIDTH = bptc_pkg::Q_W,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

### sv/bptc_scale.sv
// Three-stage scaler: raw 24-bit reading times the reciprocal of its
// oversampling scale factor, giving a Q(FRAC_BITS) value. Uses bptc_pkg.
module bptc_scale #(
    parameter int FRAC_BITS = bptc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [bptc_pkg::RAW_W-1:0]   raw_in,
    input  logic        [bptc_pkg::RATE_W-1:0]  rate_idx,
    output logic signed [FRAC_BITS+6:0]         scaled
);

    localparam int RAW_W  = bptc_pkg::RAW_W;
    localparam int RCP_W  = bptc_pkg::RECIP_W;
    localparam int PROD_W = RAW_W + RCP_W;
    localparam int PW     = FRAC_BITS + 7;
    localparam int SHIFT  = bptc_pkg::RECIP_BITS - FRAC_BITS;

    logic [RAW_W-1:0]  mag_reg, mag_next;
    logic [RCP_W-1:0]  recip_reg, recip_next;
    logic              neg1_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              neg2_reg;
    logic [PW-1:0]     sh;
    logic signed [PW-1:0] scaled_reg, scaled_next;

    always_comb begin
        mag_next    = raw_in[RAW_W-1] ? RAW_W'(-raw_in) : RAW_W'(raw_in);
        recip_next  = bptc_pkg::recip_lookup(rate_idx);
        prod_next   = PROD_W'(mag_reg) * PROD_W'(recip_reg);
        sh          = PW'(prod_reg >> SHIFT);
        scaled_next = neg2_reg ? $signed(-sh) : $signed(sh);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg    <= mag_next;
            recip_reg  <= recip_next;
            neg1_reg   <= raw_in[RAW_W-1];
            prod_reg   <= prod_next;
            neg2_reg   <= neg1_reg;
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

### sv/bptc_muli.sv
// Two-stage exact product of a signed calibration coefficient and a
// Q(FRAC_BITS) value, plus an addend. The Q operand is split in two halves
// so each partial multiplier stays narrow. Uses bptc_pkg.
module bptc_muli #(
    parameter int CW = bptc_pkg::C16_W,
    parameter int QW = bptc_pkg::FRAC_BITS_DEF + 7
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic signed [CW-1:0]            coef,
    input  logic signed [QW-1:0]            q,
    input  logic signed [bptc_pkg::Q_W-1:0] addend,
    output logic signed [bptc_pkg::Q_W-1:0] y
);

    localparam int OW   = bptc_pkg::Q_W;
    localparam int LO   = QW / 2;
    localparam int HW   = QW - LO;
    localparam int LO_P = CW + LO + 1;
    localparam int HI_P = CW + HW;

    logic signed [LO:0]      q_lo;
    logic signed [HW-1:0]    q_hi;
    logic signed [LO_P-1:0]  pp_lo_reg, pp_lo_next;
    logic signed [HI_P-1:0]  pp_hi_reg, pp_hi_next;
    logic signed [OW-1:0]    add_reg;
    logic signed [OW-1:0]    y_reg, y_next;

    always_comb begin
        q_lo       = $signed({1'b0, q[LO-1:0]});
        q_hi       = q[QW-1:LO];
        pp_lo_next = LO_P'(coef) * LO_P'(q_lo);
        pp_hi_next = HI_P'(coef) * HI_P'(q_hi);
        y_next     = (OW'(pp_hi_reg) <<< LO) + OW'(pp_lo_reg) + add_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            add_reg   <= addend;
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule

### sv/bptc_mulq.sv
// Four-stage Q(FRAC_BITS) by Q(FRAC_BITS) multiplier: sign and magnitude,
// four 32x32 partial products, the 128-bit sum, then truncation toward zero
// with saturation to the signed 64-bit range. Uses bptc_pkg.
module bptc_mulq #(
    parameter int FRAC_BITS = bptc_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic signed [bptc_pkg::Q_W-1:0] a,
    input  logic signed [bptc_pkg::Q_W-1:0] b,
    output logic signed [bptc_pkg::Q_W-1:0] y
);

    localparam int QW     = bptc_pkg::Q_W;
    localparam int HALF   = QW / 2;
    localparam int PROD_W = 2 * QW;

    logic [QW-1:0]     mag_a_reg, mag_b_reg;
    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [QW-1:0]     pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [QW-1:0]     pp00_next, pp01_next, pp10_next, pp11_next;
    logic [PROD_W-1:0] full_reg, full_next;
    logic [QW-1:0]     rlo;
    logic signed [QW-1:0] y_reg, y_next;

    always_comb begin
        pp00_next = QW'(mag_a_reg[HALF-1:0])  * QW'(mag_b_reg[HALF-1:0]);
        pp01_next = QW'(mag_a_reg[HALF-1:0])  * QW'(mag_b_reg[QW-1:HALF]);
        pp10_next = QW'(mag_a_reg[QW-1:HALF]) * QW'(mag_b_reg[HALF-1:0]);
        pp11_next = QW'(mag_a_reg[QW-1:HALF]) * QW'(mag_b_reg[QW-1:HALF]);

        full_next = {pp11_reg, pp00_reg} + (PROD_W'(pp01_reg) << HALF)
                  + (PROD_W'(pp10_reg) << HALF);

        // Any bit above the 64-bit window forces the magnitude to all ones.
        rlo = full_reg[FRAC_BITS +: QW];
        if (|full_reg[PROD_W-1:FRAC_BITS+QW]) begin
            rlo = '1;
        end
        if (neg3_reg) begin
            y_next = rlo[QW-1] ? $signed({1'b1, {(QW-1){1'b0}}}) : $signed(-rlo);
        end else begin
            y_next = rlo[QW-1] ? $signed({1'b0, {(QW-1){1'b1}}}) : $signed(rlo);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg <= bptc_pkg::mag64(a);
            mag_b_reg <= bptc_pkg::mag64(b);
            neg1_reg  <= a[QW-1] ^ b[QW-1];
            pp00_reg  <= pp00_next;
            pp01_reg  <= pp01_next;
            pp10_reg  <= pp10_next;
            pp11_reg  <= pp11_next;
            neg2_reg  <= neg1_reg;
            full_reg  <= full_next;
            neg3_reg  <= neg2_reg;
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule
